### rtl/mm_pkg.sv
// Shared types and constants for the integer matrix multiplier.
// No dependencies; used by matrix_multiply and mm_checker.
`timescale 1ns / 1ps

package mm_pkg;

  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int SUM_W     = 35;
  localparam int OP_W      = 2;
  localparam int POS_W     = 3;
  localparam int CFG_DIM_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Bookkeeping that travels with each multiply-accumulate step
  typedef struct packed {
    logic             first;  // first inner step of a result entry
    logic             lastw;  // last inner step of a result entry
    logic             fin;    // last step of the whole compute
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

endpackage

### rtl/matrix_multiply.sv
// Integer matrix multiplier C = A x B with one shared multiply-accumulate pipeline.
// Depends on mm_pkg (types, widths, operation and register codes).
// A compute walks every inner product step of the clamped dimensions, one step
// per cycle through a single 16x16 multiplier; a load never raises busy, and
// busy stays high until the final step leaves the accumulator.
// Reset (synchronous, rst_n low) clears control and sets all dimensions to 1;
// the A and B stores are not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [mm_pkg::OP_W-1:0]             in_operation,
  input  logic [mm_pkg::POS_W-1:0]            in_row,
  input  logic [mm_pkg::POS_W-1:0]            in_col,
  input  logic signed [mm_pkg::VAL_W-1:0]     in_value,
  // result channel
  output logic                                out_strobe,
  output logic [mm_pkg::POS_W-1:0]            out_row,
  output logic [mm_pkg::POS_W-1:0]            out_col,
  output logic signed [mm_pkg::SUM_W-1:0]     out_product_sum,
  output logic                                out_last,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mm_pkg::CFG_DIM_W-1:0]        cfg_wdata
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers (raw 4-bit values, clamped when a compute starts)
  // ---------------------------------------------------------------------------
  logic [mm_pkg::CFG_DIM_W-1:0] rows_a_r, inner_size_r, cols_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= mm_pkg::CFG_DIM_W'(1);
      inner_size_r <= mm_pkg::CFG_DIM_W'(1);
      cols_b_r     <= mm_pkg::CFG_DIM_W'(1);
    end else if (cfg_we) begin
      case (mm_pkg::cfg_idx_t'(cfg_index))
        mm_pkg::CFG_ROWS_A:     rows_a_r     <= cfg_wdata;
        mm_pkg::CFG_INNER_SIZE: inner_size_r <= cfg_wdata;
        mm_pkg::CFG_COLS_B:     cols_b_r     <= cfg_wdata;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Zero reads as one, anything above MAX_DIM saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [mm_pkg::CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0)
      d = DIM_W'(1);
    else if (32'(v) > MAX_DIM)
      d = DIM_W'(MAX_DIM);
    else
      d = DIM_W'(v);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  mm_pkg::state_t state_r, state_nxt;
  logic accept;
  logic load_in_range;
  logic [IDX_W-1:0] load_addr;

  assign busy          = (state_r != mm_pkg::ST_IDLE);
  assign accept        = start && !busy;
  assign load_in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign load_addr     = IDX_W'(32'(in_row) * MAX_DIM + 32'(in_col));

  // ---------------------------------------------------------------------------
  // Sequencer: walk (i, j, w) in row-major order, one inner step per cycle
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] ra_r, ka_r, cb_r;
  logic [CNT_W-1:0] i_r, j_r, w_r;
  logic [CNT_W-1:0] i_nxt, j_nxt, w_nxt;
  logic             last_i, last_j, last_w;
  logic             issue;
  mm_pkg::tag_t     issue_tag;
  logic             s2_vld_r;
  mm_pkg::tag_t     s2_tag_r;

  assign last_i = (32'(i_r) == 32'(ra_r) - 1);
  assign last_j = (32'(j_r) == 32'(cb_r) - 1);
  assign last_w = (32'(w_r) == 32'(ka_r) - 1);
  assign issue  = (state_r == mm_pkg::ST_RUN);

  always_comb begin
    issue_tag.first = (w_r == '0);
    issue_tag.lastw = last_w;
    issue_tag.fin   = last_w && last_j && last_i;
    issue_tag.row   = mm_pkg::POS_W'(i_r);
    issue_tag.col   = mm_pkg::POS_W'(j_r);
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    w_nxt     = w_r;
    case (state_r)
      mm_pkg::ST_IDLE: begin
        if (accept && mm_pkg::op_t'(in_operation) == mm_pkg::OP_COMPUTE) begin
          state_nxt = mm_pkg::ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          w_nxt     = '0;
        end
      end
      mm_pkg::ST_RUN: begin
        // advance the inner index, carry into column then row
        w_nxt = last_w ? '0 : w_r + CNT_W'(1);
        if (last_w) begin
          j_nxt = last_j ? '0 : j_r + CNT_W'(1);
          if (last_j)
            i_nxt = i_r + CNT_W'(1);
        end
        if (issue_tag.fin)
          state_nxt = mm_pkg::ST_DRAIN;
      end
      mm_pkg::ST_DRAIN: begin
        // hold until the final step leaves the accumulator
        if (s2_vld_r && s2_tag_r.fin)
          state_nxt = mm_pkg::ST_IDLE;
      end
      default: state_nxt = mm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      w_r     <= '0;
      ra_r    <= DIM_W'(1);
      ka_r    <= DIM_W'(1);
      cb_r    <= DIM_W'(1);
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      w_r     <= w_nxt;
      // latch clamped dimensions for the whole compute
      if (state_r == mm_pkg::ST_IDLE) begin
        ra_r <= clamp_dim(rows_a_r);
        ka_r <= clamp_dim(inner_size_r);
        cb_r <= clamp_dim(cols_b_r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Element stores: one write port (loads), one registered read port each
  // ---------------------------------------------------------------------------
  logic [mm_pkg::VAL_W-1:0] mem_a [STORE_DEPTH];
  logic [mm_pkg::VAL_W-1:0] mem_b [STORE_DEPTH];
  logic [IDX_W-1:0]         rd_addr_a, rd_addr_b;
  logic signed [mm_pkg::VAL_W-1:0] a_rd_r, b_rd_r;

  assign rd_addr_a = IDX_W'(32'(i_r) * MAX_DIM + 32'(w_r));
  assign rd_addr_b = IDX_W'(32'(w_r) * MAX_DIM + 32'(j_r));

  always_ff @(posedge clk) begin
    if (accept && load_in_range && mm_pkg::op_t'(in_operation) == mm_pkg::OP_LOAD_A)
      mem_a[load_addr] <= in_value;
    a_rd_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (accept && load_in_range && mm_pkg::op_t'(in_operation) == mm_pkg::OP_LOAD_B)
      mem_b[load_addr] <= in_value;
    b_rd_r <= mem_b[rd_addr_b];
  end

  // ---------------------------------------------------------------------------
  // Shared MAC pipeline: read -> multiply -> accumulate/emit
  // ---------------------------------------------------------------------------
  logic                             s1_vld_r;
  mm_pkg::tag_t                     s1_tag_r;
  logic signed [mm_pkg::PROD_W-1:0] prod_r;
  logic signed [mm_pkg::SUM_W-1:0]  acc_r;
  logic signed [mm_pkg::SUM_W-1:0]  acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= issue_tag;
    s2_tag_r <= s1_tag_r;
    prod_r   <= a_rd_r * b_rd_r;
  end

  // Restart the sum on the first inner step of each entry
  assign acc_nxt = (s2_tag_r.first ? '0 : acc_r)
                 + mm_pkg::SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (s2_vld_r)
      acc_r <= acc_nxt;
  end

  // Output register: one-cycle strobe per finished entry
  logic                            out_strobe_r;
  logic [mm_pkg::POS_W-1:0]        out_row_r, out_col_r;
  logic signed [mm_pkg::SUM_W-1:0] out_sum_r;
  logic                            out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_strobe_r <= 1'b0;
    else
      out_strobe_r <= s2_vld_r && s2_tag_r.lastw;
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_tag_r.lastw) begin
      out_row_r  <= s2_tag_r.row;
      out_col_r  <= s2_tag_r.col;
      out_sum_r  <= acc_nxt;
      out_last_r <= s2_tag_r.fin;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_product_sum = out_sum_r;
  assign out_last        = out_strobe_r && out_last_r;

endmodule

### rtl/mm_checker.sv
// Port-level checks for matrix_multiply, attached by bind.
// Depends on mm_pkg (operation codes).
`timescale 1ns / 1ps

module mm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [mm_pkg::OP_W-1:0]     in_operation,
  input logic                        out_strobe,
  input logic                        out_last
);

  // every result belongs to a compute that was running
  a_strobe_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a running compute");

  // the final result closes the compute
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("busy still high on final result");

  // intermediate results only while still busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("intermediate result after compute ended");

  // a compute transaction makes the block busy
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == mm_pkg::OP_COMPUTE |=> busy)
    else $error("compute accepted but block not busy");

  // loads and unused codes leave the block idle and produce no result
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != mm_pkg::OP_COMPUTE |=> !busy && !out_strobe)
    else $error("load transaction left block busy or produced a result");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .out_strobe   (out_strobe),
  .out_last     (out_last)
);
